// File: hw/rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// types and codes shared by the best-fit allocator controller and datapath
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_NULL    = 2'd3;

    localparam logic [15:0] ARENA_RESET = 16'd4096;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHU_CHK,
        S_SHU_RD,
        S_SHU_WR,
        S_SPLIT_WR,
        S_GRANT_WR,
        S_RD_PREV,
        S_RD_NEXT,
        S_CAP_NEXT,
        S_MERGE,
        S_SHD_CHK,
        S_SHD_RD,
        S_SHD_WR,
        S_INIT_WR,
        S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_START,
        CMD_SCAN,
        CMD_DECIDE,
        CMD_SHU_RD,
        CMD_SHU_WR,
        CMD_SPLIT_WR,
        CMD_GRANT_WR,
        CMD_RD_PREV,
        CMD_RD_NEXT,
        CMD_CAP_NEXT,
        CMD_MERGE,
        CMD_SHD_RD,
        CMD_SHD_WR,
        CMD_SHD_END,
        CMD_INIT_WR,
        CMD_RESULT
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic is_alloc;
        logic is_free;
        logic found;
        logic null_off;
        logic split;
        logic shu_more;
        logic shd_more;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// sequencer for init write, table scan, insert shift, split and grant writes, merge and remove shift
// ----------------------------------------------------------------------------
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_req_type,
    input  t_status    i_sts,
    output logic       o_stall,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = CMD_START;
                    n_state = (i_req_type == REQ_INIT) ? S_INIT_WR : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd = CMD_SCAN;
                end else begin
                    o_cmd = CMD_DECIDE;
                    if (i_sts.is_alloc) begin
                        if (!i_sts.found) begin
                            n_state = S_RESULT;
                        end else if (i_sts.split) begin
                            n_state = S_SHU_CHK;
                        end else begin
                            n_state = S_GRANT_WR;
                        end
                    end else if (i_sts.is_free) begin
                        n_state = (i_sts.null_off || !i_sts.found) ? S_RESULT : S_RD_PREV;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SHU_CHK: begin
                n_state = i_sts.shu_more ? S_SHU_RD : S_SPLIT_WR;
            end
            S_SHU_RD: begin
                o_cmd   = CMD_SHU_RD;
                n_state = S_SHU_WR;
            end
            S_SHU_WR: begin
                o_cmd   = CMD_SHU_WR;
                n_state = S_SHU_CHK;
            end
            S_SPLIT_WR: begin
                o_cmd   = CMD_SPLIT_WR;
                n_state = S_GRANT_WR;
            end
            S_GRANT_WR: begin
                o_cmd   = CMD_GRANT_WR;
                n_state = S_RESULT;
            end
            S_RD_PREV: begin
                o_cmd   = CMD_RD_PREV;
                n_state = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                o_cmd   = CMD_RD_NEXT;
                n_state = S_CAP_NEXT;
            end
            S_CAP_NEXT: begin
                o_cmd   = CMD_CAP_NEXT;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                o_cmd   = CMD_MERGE;
                n_state = S_SHD_CHK;
            end
            S_SHD_CHK: begin
                if (i_sts.shd_more) begin
                    n_state = S_SHD_RD;
                end else begin
                    o_cmd   = CMD_SHD_END;
                    n_state = S_RESULT;
                end
            end
            S_SHD_RD: begin
                o_cmd   = CMD_SHD_RD;
                n_state = S_SHD_WR;
            end
            S_SHD_WR: begin
                o_cmd   = CMD_SHD_WR;
                n_state = S_SHD_CHK;
            end
            S_INIT_WR: begin
                o_cmd   = CMD_INIT_WR;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd   = CMD_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp
// block table memory, scan registers, merge arithmetic and result register
// ----------------------------------------------------------------------------
module bfa_dp
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int OFFSET_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_sts,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_free_offset,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_data_offset,
    output logic [15:0] o_granted_size
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int OB = OFFSET_BITS;
    localparam int EW = OB + 17;

    localparam logic [OB-1:0] HDR_OFF  = OB'(HEADER_BYTES);
    localparam logic [15:0]   HDR_SIZE = 16'(HEADER_BYTES);
    localparam logic [16:0]   HDR_WIDE = 17'(HEADER_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_arena;
    logic [1:0]    r_type, n_type;
    logic [15:0]   r_req, n_req;
    logic [15:0]   r_foff, n_foff;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_found, n_found;
    logic          r_split, n_split;
    logic [IW-1:0] r_best, n_best;
    logic [15:0]   r_slack, n_slack;
    logic [15:0]   r_bsize, n_bsize;
    logic [OB-1:0] r_bhdr, n_bhdr;
    logic [EW-1:0] r_prev, n_prev;
    logic [EW-1:0] r_next, n_next;
    logic [1:0]    r_dist, n_dist;
    logic [1:0]    r_rst, n_rst;
    logic [15:0]   r_roff, n_roff;
    logic [15:0]   r_rsz, n_rsz;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ost, n_ost;
    logic [15:0]   r_ooff, n_ooff;
    logic [15:0]   r_osz, n_osz;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic [OB-1:0] e_hdr, e_doff, b_doff;
    logic [15:0]   e_size, e_slack;
    logic          e_used, e_fits, e_match;
    logic          in_range, has_prev, has_next, pf, nf;
    logic [CW:0]   cur_p1;
    logic [15:0]   sum_pc, sum_cn;

    bfa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign e_hdr   = rdata[EW-1:17];
    assign e_size  = rdata[16:1];
    assign e_used  = rdata[0];
    assign e_doff  = e_hdr + HDR_OFF;
    assign e_fits  = !e_used && (e_size >= r_req);
    assign e_slack = e_size - r_req;
    assign e_match = e_used && (32'(e_doff) == 32'(r_foff));
    assign b_doff  = r_bhdr + HDR_OFF;

    assign in_range = (r_idx < r_count);
    assign cur_p1   = (CW+1)'(r_best) + 1'b1;
    assign has_prev = (r_best != '0);
    assign has_next = (cur_p1 < (CW+1)'(r_count));
    assign pf       = has_prev && !r_prev[0];
    assign nf       = has_next && !r_next[0];
    assign sum_pc   = r_prev[16:1] + r_bsize + HDR_SIZE;
    assign sum_cn   = r_next[16:1] + HDR_SIZE;

    always_comb begin
        o_sts.scan_done = !in_range && !r_pend;
        o_sts.is_alloc  = (r_type == REQ_ALLOC);
        o_sts.is_free   = (r_type == REQ_FREE);
        o_sts.found     = r_found;
        o_sts.null_off  = (r_foff == '0);
        o_sts.split     = ((17'(r_req) + HDR_WIDE) < 17'(r_bsize)) &&
                          (r_count < CW'(MAX_BLOCKS));
        o_sts.shu_more  = ((CW+1)'(r_idx) > cur_p1);
        o_sts.shd_more  = (r_dist != '0) &&
                          (((CW+1)'(r_idx) + (CW+1)'(r_dist)) < (CW+1)'(r_count));
        o_sts.out_free  = !r_ovalid || !i_stall;
    end

    always_comb begin
        n_count  = r_count;
        n_type   = r_type;
        n_req    = r_req;
        n_foff   = r_foff;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_found  = r_found;
        n_split  = r_split;
        n_best   = r_best;
        n_slack  = r_slack;
        n_bsize  = r_bsize;
        n_bhdr   = r_bhdr;
        n_prev   = r_prev;
        n_next   = r_next;
        n_dist   = r_dist;
        n_rst    = r_rst;
        n_roff   = r_roff;
        n_rsz    = r_rsz;
        n_ovalid = r_ovalid && i_stall;
        n_ost    = r_ost;
        n_ooff   = r_ooff;
        n_osz    = r_osz;
        we       = 1'b0;
        waddr    = r_best;
        wdata    = rdata;
        raddr    = r_idx[IW-1:0];
        case (i_cmd)
            CMD_START: begin
                n_type  = i_req_type;
                n_req   = i_req_size;
                n_foff  = i_free_offset;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_found = 1'b0;
            end
            CMD_SCAN: begin
                n_pend = in_range;
                n_pidx = r_idx[IW-1:0];
                if (in_range) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (r_type == REQ_ALLOC && e_fits && (!r_found || e_slack < r_slack)) begin
                        n_found = 1'b1;
                        n_best  = r_pidx;
                        n_slack = e_slack;
                        n_bsize = e_size;
                        n_bhdr  = e_hdr;
                    end
                    if (r_type == REQ_FREE && e_match && !r_found) begin
                        n_found = 1'b1;
                        n_best  = r_pidx;
                        n_bsize = e_size;
                        n_bhdr  = e_hdr;
                    end
                end
            end
            CMD_DECIDE: begin
                n_split = o_sts.split;
                n_idx   = r_count;
                n_roff  = '0;
                n_rsz   = '0;
                if (r_type == REQ_ALLOC) begin
                    n_rst = ST_NO_FIT;
                end else if (r_type == REQ_FREE) begin
                    if (r_foff == '0) begin
                        n_rst = ST_NULL;
                    end else if (!r_found) begin
                        n_rst = ST_UNKNOWN;
                    end else begin
                        n_rst = ST_OK;
                    end
                end else begin
                    n_rst = ST_OK;
                end
            end
            CMD_SHU_RD: begin
                raddr = r_idx[IW-1:0] - 1'b1;
            end
            CMD_SHU_WR: begin
                we    = 1'b1;
                waddr = r_idx[IW-1:0];
                n_idx = r_idx - 1'b1;
            end
            CMD_SPLIT_WR: begin
                we      = 1'b1;
                waddr   = r_best + 1'b1;
                wdata   = {b_doff + OB'(r_req), r_bsize - r_req - HDR_SIZE, 1'b0};
                n_count = r_count + 1'b1;
            end
            CMD_GRANT_WR: begin
                we     = 1'b1;
                waddr  = r_best;
                wdata  = {r_bhdr, r_split ? r_req : r_bsize, 1'b1};
                n_rst  = ST_OK;
                n_roff = 16'(b_doff);
                n_rsz  = r_split ? r_req : r_bsize;
            end
            CMD_RD_PREV: begin
                raddr = r_best - 1'b1;
            end
            CMD_RD_NEXT: begin
                raddr  = r_best + 1'b1;
                n_prev = rdata;
            end
            CMD_CAP_NEXT: begin
                n_next = rdata;
            end
            CMD_MERGE: begin
                we = 1'b1;
                if (pf) begin
                    waddr  = r_best - 1'b1;
                    wdata  = {r_prev[EW-1:17], nf ? sum_pc + sum_cn : sum_pc, 1'b0};
                    n_idx  = CW'(r_best);
                    n_dist = nf ? 2'd2 : 2'd1;
                end else begin
                    waddr  = r_best;
                    wdata  = {r_bhdr, nf ? r_bsize + sum_cn : r_bsize, 1'b0};
                    n_idx  = CW'(cur_p1);
                    n_dist = nf ? 2'd1 : 2'd0;
                end
            end
            CMD_SHD_RD: begin
                raddr = r_idx[IW-1:0] + IW'(r_dist);
            end
            CMD_SHD_WR: begin
                we    = 1'b1;
                waddr = r_idx[IW-1:0];
                n_idx = r_idx + 1'b1;
            end
            CMD_SHD_END: begin
                n_count = r_count - CW'(r_dist);
            end
            CMD_INIT_WR: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = {{OB{1'b0}}, (r_arena > HDR_SIZE) ? r_arena - HDR_SIZE : 16'd0, 1'b0};
                n_count = CW'(1);
                n_rst   = ST_OK;
                n_roff  = '0;
                n_rsz   = '0;
            end
            CMD_RESULT: begin
                n_ovalid = 1'b1;
                n_ost    = r_rst;
                n_ooff   = r_roff;
                n_osz    = r_rsz;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_arena  <= ARENA_RESET;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_dist   <= '0;
        end else begin
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_dist   <= n_dist;
            if (i_cfg_we) begin
                r_arena <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_req   <= n_req;
        r_foff  <= n_foff;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_found <= n_found;
        r_split <= n_split;
        r_best  <= n_best;
        r_slack <= n_slack;
        r_bsize <= n_bsize;
        r_bhdr  <= n_bhdr;
        r_prev  <= n_prev;
        r_next  <= n_next;
        r_rst   <= n_rst;
        r_roff  <= n_roff;
        r_rsz   <= n_rsz;
        r_ost   <= n_ost;
        r_ooff  <= n_ooff;
        r_osz   <= n_osz;
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ost;
    assign o_data_offset  = r_ooff;
    assign o_granted_size = r_osz;

endmodule

// File: hw/rtl/best_fit_block_allocator_top.sv
// sequence: an init writes one entry; any other request scans the table over n blocks, then
// a grant, split or merge writes the entries, and a split that inserts or a merge that removes
// an entry moves each later entry with a read and a write, one at a time through the one read
// port of the block table
// throughput: one item at a time; the next item is taken once the result is registered
// reset: synchronous active low; table empty (no blocks until an init item), arena_size 4096
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// best-fit arena allocator with splitting and coalescing of free blocks
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int OFFSET_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_free_offset,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_data_offset,
    output logic [15:0] o_granted_size,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status sts;

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_stall    (o_stall),
        .o_cmd      (cmd)
    );

    bfa_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_data_offset  (o_data_offset),
        .o_granted_size (o_granted_size)
    );

endmodule

// File: sim/best_fit_block_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top_tb
// drives allocate, free, init and unused-type items into the best-fit allocator, predicts
// each result from its own copy of the block table and compares every result
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top_tb;
    import bfa_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int HDR = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] data_offset;
        logic [15:0] granted_size;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = REQ_INIT;
    logic [15:0] i_req_size = '0;
    logic [15:0] i_free_offset = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_data_offset;
    logic [15:0] o_granted_size;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    // predicted block table
    logic [15:0]   blk_hdr [TABLE_DEPTH];
    logic [15:0]   blk_size [TABLE_DEPTH];
    bit            blk_used [TABLE_DEPTH];
    int            blk_count = 0;
    logic [15:0]   arena_bytes = ARENA_RESET;

    t_alloc_result pending_results[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            idle_enable = 1'b1;

    best_fit_block_allocator_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_data_offset  (o_data_offset),
        .o_granted_size (o_granted_size),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] data_addr(int i);
        return blk_hdr[i] + 16'(HDR);
    endfunction

    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < blk_count; k++) begin
            blk_hdr[k]  = blk_hdr[k + 1];
            blk_size[k] = blk_size[k + 1];
            blk_used[k] = blk_used[k + 1];
        end
        blk_count--;
    endfunction

    function automatic t_alloc_result allocate_or_release(logic [1:0] kind, logic [15:0] size,
                                                          logic [15:0] offset);
        t_alloc_result r;
        int best;
        int best_slack;
        int cur;
        r = '{ST_OK, 16'd0, 16'd0};
        if (kind == REQ_INIT) begin
            blk_hdr[0]  = '0;
            blk_size[0] = (arena_bytes > HDR) ? arena_bytes - 16'(HDR) : 16'd0;
            blk_used[0] = 1'b0;
            blk_count   = 1;
        end else if (kind == REQ_ALLOC) begin
            best = -1;
            best_slack = 0;
            for (int i = 0; i < blk_count; i++) begin
                if (!blk_used[i] && blk_size[i] >= size &&
                    (best < 0 || int'(blk_size[i]) - int'(size) < best_slack)) begin
                    best = i;
                    best_slack = int'(blk_size[i]) - int'(size);
                end
            end
            if (best < 0) begin
                r.status = ST_NO_FIT;
            end else begin
                if (int'(size) + HDR < int'(blk_size[best]) && blk_count < TABLE_DEPTH) begin
                    for (int k = blk_count; k > best + 1; k--) begin
                        blk_hdr[k]  = blk_hdr[k - 1];
                        blk_size[k] = blk_size[k - 1];
                        blk_used[k] = blk_used[k - 1];
                    end
                    blk_hdr[best + 1]  = data_addr(best) + size;
                    blk_size[best + 1] = 16'(int'(blk_size[best]) - int'(size) - HDR);
                    blk_used[best + 1] = 1'b0;
                    blk_size[best] = size;
                    blk_count++;
                end
                blk_used[best] = 1'b1;
                r.data_offset  = data_addr(best);
                r.granted_size = blk_size[best];
            end
        end else if (kind == REQ_FREE) begin
            cur = -1;
            if (offset == 16'd0) begin
                r.status = ST_NULL;
                return r;
            end
            for (int i = 0; i < blk_count; i++) begin
                if (cur < 0 && blk_used[i] && data_addr(i) == offset) cur = i;
            end
            if (cur < 0) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            if (cur > 0 && !blk_used[cur - 1]) begin
                blk_size[cur - 1] = blk_size[cur - 1] + blk_size[cur] + 16'(HDR);
                drop_entry(cur);
                cur--;
            end else begin
                blk_used[cur] = 1'b0;
            end
            if (cur + 1 < blk_count && !blk_used[cur + 1]) begin
                blk_size[cur] = blk_size[cur] + blk_size[cur + 1] + 16'(HDR);
                drop_entry(cur + 1);
            end
        end
        return r;
    endfunction

    task automatic send_item(logic [1:0] kind, logic [15:0] size, logic [15:0] offset);
        if (idle_enable && $urandom_range(0, 99) < 18)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        i_req_type    = kind;
        i_req_size    = size;
        i_free_offset = offset;
        i_valid       = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        pending_results.push_back(allocate_or_release(kind, size, offset));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_results.size() == 0);
        @(negedge i_clk);
    endtask

    task automatic write_arena(logic [15:0] value);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        arena_bytes = value;
    endtask

    // offset of a random allocated block, or a random value when none is held
    function automatic logic [15:0] pick_live_offset();
        int held[$];
        for (int i = 0; i < blk_count; i++)
            if (blk_used[i]) held.push_back(i);
        if (held.size() == 0) return 16'($urandom);
        return data_addr(held[$urandom_range(0, held.size() - 1)]);
    endfunction

    task automatic test_before_init();
        send_item(REQ_ALLOC, 16'd0, 16'd0);
        send_item(REQ_FREE, 16'd0, 16'd24);
        send_item(REQ_FREE, 16'd0, 16'd0);
        send_item(REQ_SPARE, 16'hffff, 16'hffff);
    endtask

    task automatic test_directed();
        write_arena(16'd1000);
        send_item(REQ_INIT, 16'd0, 16'd0);
        send_item(REQ_ALLOC, 16'hffff, 16'd0);
        send_item(REQ_ALLOC, 16'd0, 16'd0);
        send_item(REQ_ALLOC, 16'd100, 16'd0);
        send_item(REQ_ALLOC, 16'd200, 16'd0);
        send_item(REQ_ALLOC, 16'd50, 16'd0);
        send_item(REQ_FREE, 16'd0, 16'd48);
        send_item(REQ_FREE, 16'd0, 16'd172);
        send_item(REQ_FREE, 16'd0, 16'd172);
        send_item(REQ_FREE, 16'd0, 16'd0);
        send_item(REQ_ALLOC, 16'd276, 16'd0);
        send_item(REQ_ALLOC, 16'd8, 16'd0);
        send_item(REQ_SPARE, 16'd5, 16'd24);
        send_item(REQ_FREE, 16'd0, 16'd24);
        send_item(REQ_FREE, 16'd0, 16'hffff);
        // exact fit, split edge with no room for a header
        write_arena(16'd32);
        send_item(REQ_INIT, 16'd0, 16'd0);
        send_item(REQ_ALLOC, 16'd9, 16'd0);
        send_item(REQ_ALLOC, 16'd8, 16'd0);
        send_item(REQ_FREE, 16'd0, 16'd24);
        write_arena(16'd65535);
        send_item(REQ_INIT, 16'd0, 16'd0);
        send_item(REQ_ALLOC, 16'd65511, 16'd0);
        send_item(REQ_FREE, 16'd0, 16'd24);
    endtask

    task automatic test_full_table();
        write_arena(16'd4096);
        send_item(REQ_INIT, 16'd0, 16'd0);
        for (int n = 0; n < 70; n++)
            send_item(REQ_ALLOC, 16'($urandom_range(1, 30)), 16'd0);
        while (blk_count > 1 || blk_used[0])
            send_item(REQ_FREE, 16'd0, pick_live_offset());
    endtask

    task automatic test_random();
        logic [15:0] settings [4] = '{16'd4096, 16'd32, 16'd65535, 16'd700};
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            write_arena(settings[phase]);
            send_item(REQ_INIT, 16'd0, 16'd0);
            for (int n = 0; n < 72; n++) begin
                idle_enable = !(phase == 1);
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_item(REQ_ALLOC, 16'($urandom_range(0, 150)), 16'($urandom));
                else if (pick < 58)
                    send_item(REQ_ALLOC, 16'($urandom), 16'($urandom));
                else if (pick < 85)
                    send_item(REQ_FREE, 16'($urandom), pick_live_offset());
                else if (pick < 92)
                    send_item(REQ_FREE, 16'($urandom), 16'($urandom));
                else if (pick < 94)
                    send_item(REQ_FREE, 16'($urandom), 16'd0);
                else if (pick < 97)
                    send_item(REQ_INIT, 16'($urandom), 16'($urandom));
                else
                    send_item(REQ_SPARE, 16'($urandom), 16'($urandom));
                if (n == 50) wait_drained();
            end
        end
        idle_enable = 1'b1;
    endtask

    always @(negedge i_clk)
        i_stall <= idle_enable && ($urandom_range(0, 99) < 18);

    always @(posedge i_clk) begin
        t_alloc_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d offset %0d size %0d",
                         $time, o_status, o_data_offset, o_granted_size);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    error_count++;
                end
                if (o_data_offset !== exp_r.data_offset) begin
                    $display("%0t: data_offset expected %0d actual %0d",
                             $time, exp_r.data_offset, o_data_offset);
                    error_count++;
                end
                if (o_granted_size !== exp_r.granted_size) begin
                    $display("%0t: granted_size expected %0d actual %0d",
                             $time, exp_r.granted_size, o_granted_size);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_before_init();
        test_directed();
        test_full_table();
        test_random();
        wait (pending_results.size() == 0);
        repeat (250) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: best_fit_block_allocator_top.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bfa_dp.sv
hw/rtl/best_fit_block_allocator_top.sv
sim/best_fit_block_allocator_top_tb.sv
